FILE: hw/rtl/lzssd_pkg.sv
// ----------------------------------------------------------------------------
// lzssd_pkg
// Shared constants and types for the lzss stream decompressor.
// ----------------------------------------------------------------------------
package lzssd_pkg;

  localparam int MIN_MATCH  = 3;
  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  // slot counter of one back-reference, wide enough for the longest match
  localparam int LEN_W      = $clog2(MIN_MATCH + 16);

  // command kinds from the parser to the copy engine
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_LIT  = 2'd1;
  localparam logic [1:0] CMD_COPY = 2'd2;

  // frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CORRUPT  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         lit;
    logic [HIST_AW-1:0] offset;
    logic [3:0]         len_code;
    logic               done;
    logic [1:0]         status;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       run_last;
    logic       frame_done;
    logic [1:0] status;
  } res_t;

endpackage

FILE: hw/rtl/lzssd_front.sv
// ----------------------------------------------------------------------------
// lzssd_front
// Frame parser: header, flag bytes and tokens, turned into copy commands.
// ----------------------------------------------------------------------------
module lzssd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output logic               cmd_push,
  output lzssd_pkg::cmd_t    cmd,
  input  logic               cmd_full
);

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_FLAG     = 3'd1;
  localparam logic [2:0] PH_DATA     = 3'd2;
  localparam logic [2:0] PH_REF_HI   = 3'd3;
  localparam logic [2:0] PH_DONE     = 3'd4;
  localparam logic [2:0] PH_CORRUPT  = 3'd5;
  localparam logic [2:0] PH_OVERFLOW = 3'd6;

  logic [31:0] capacity;
  logic [2:0]  phase, phase_next;
  logic [1:0]  hidx, hidx_next;
  logic [31:0] total, total_next;
  logic [31:0] produced, produced_next;
  logic [31:0] remaining, remaining_next;
  logic [7:0]  flags, flags_next;
  logic [2:0]  fidx, fidx_next;
  logic [7:0]  off_lo, off_lo_next;

  logic [31:0]                  hdr_size;
  logic [lzssd_pkg::LEN_W-1:0]  ref_len;
  logic [lzssd_pkg::HIST_AW-1:0] ref_off;
  logic                         ref_bad;
  logic                         advance;
  logic                         fin;
  logic                         accept;

  assign in_ready  = !cmd_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign cmd_push  = accept;

  assign hdr_size = (hidx == 2'd0) ? 32'(in_byte)
                                   : (total | (32'(in_byte) << {hidx, 3'b000}));
  assign ref_off  = {in_byte[7:4], off_lo};
  assign ref_len  = lzssd_pkg::LEN_W'(in_byte[3:0]) + lzssd_pkg::LEN_W'(lzssd_pkg::MIN_MATCH);
  assign ref_bad  = (ref_off == '0) || (32'(ref_off) > produced) ||
                    (remaining < 32'(ref_len));

  always_comb begin
    phase_next     = phase;
    hidx_next      = hidx;
    total_next     = total;
    produced_next  = produced;
    remaining_next = remaining;
    flags_next     = flags;
    fidx_next      = fidx;
    off_lo_next    = off_lo;
    advance        = 1'b0;
    fin            = 1'b0;
    cmd            = '0;
    cmd.kind       = lzssd_pkg::CMD_NONE;
    cmd.offset     = ref_off;
    cmd.len_code   = in_byte[3:0];

    unique case (phase)
      PH_HEADER: begin
        total_next = hdr_size;
        if (hidx == 2'd3) begin
          hidx_next      = 2'd0;
          produced_next  = '0;
          remaining_next = hdr_size;
          fidx_next      = 3'd0;
          if (hdr_size > capacity) begin
            phase_next = PH_OVERFLOW;
          end else if (hdr_size == '0) begin
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_FLAG;
          end
        end else begin
          hidx_next = hidx + 2'd1;
        end
      end
      PH_FLAG: begin
        flags_next = in_byte;
        fidx_next  = 3'd0;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        if (flags[fidx]) begin
          off_lo_next = in_byte;
          phase_next  = PH_REF_HI;
        end else begin
          cmd.kind       = lzssd_pkg::CMD_LIT;
          cmd.lit        = in_byte;
          produced_next  = produced + 32'd1;
          remaining_next = remaining - 32'd1;
          advance        = 1'b1;
          fin            = (remaining == 32'd1);
        end
      end
      PH_REF_HI: begin
        if (ref_bad) begin
          phase_next = PH_CORRUPT;
        end else begin
          cmd.kind       = lzssd_pkg::CMD_COPY;
          produced_next  = produced + 32'(ref_len);
          remaining_next = remaining - 32'(ref_len);
          advance        = 1'b1;
          fin            = (remaining == 32'(ref_len));
        end
      end
      default: ;
    endcase

    if (advance) begin
      if (fin) begin
        phase_next = PH_DONE;
      end else if (fidx == 3'd7) begin
        fidx_next  = 3'd0;
        phase_next = PH_FLAG;
      end else begin
        fidx_next  = fidx + 3'd1;
        phase_next = PH_DATA;
      end
    end

    // frame cut short
    if (in_last && phase_next != PH_DONE && phase_next != PH_CORRUPT &&
        phase_next != PH_OVERFLOW) begin
      phase_next = PH_CORRUPT;
    end

    cmd.done   = (phase_next == PH_DONE);
    cmd.status = (phase_next == PH_CORRUPT)  ? lzssd_pkg::ST_CORRUPT :
                 (phase_next == PH_OVERFLOW) ? lzssd_pkg::ST_OVERFLOW : lzssd_pkg::ST_OK;

    if (in_last) begin
      phase_next = PH_HEADER;
      hidx_next  = 2'd0;
      fidx_next  = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= '1;
      phase     <= PH_HEADER;
      hidx      <= '0;
      total     <= '0;
      produced  <= '0;
      remaining <= '0;
      flags     <= '0;
      fidx      <= '0;
      off_lo    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        phase     <= phase_next;
        hidx      <= hidx_next;
        total     <= total_next;
        produced  <= produced_next;
        remaining <= remaining_next;
        flags     <= flags_next;
        fidx      <= fidx_next;
        off_lo    <= off_lo_next;
      end
    end
  end

endmodule

FILE: hw/rtl/lzssd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lzssd_cmd_fifo
// Two-entry command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzssd_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lzssd_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output lzssd_pkg::cmd_t head
);

  lzssd_pkg::cmd_t entries [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("command pushed into full queue");

endmodule

FILE: hw/rtl/lzssd_back.sv
// ----------------------------------------------------------------------------
// lzssd_back
// Copy engine: history ring, result queue, one byte per cycle when not full.
// ----------------------------------------------------------------------------
module lzssd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  lzssd_pkg::cmd_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output lzssd_pkg::res_t out_res
);

  localparam int AW = lzssd_pkg::HIST_AW;

  logic [7:0]                  mem [lzssd_pkg::HIST_DEPTH];
  logic [7:0]                  rd_q;
  logic                        byp;
  logic [7:0]                  byp_data;
  logic [AW-1:0]               raddr;
  logic [AW-1:0]               wp_issue;
  logic [lzssd_pkg::LEN_W-1:0] cnt;
  logic [lzssd_pkg::LEN_W-1:0] last_idx;

  logic                        issue;
  logic                        slot_last;
  logic                        slot_byte;

  // stage b: byte fetched from history
  logic                        b_valid;
  logic                        b_copy;
  logic [7:0]                  b_lit;
  logic                        b_bvalid;
  logic                        b_last;
  logic                        b_done;
  logic [1:0]                  b_status;
  logic [AW-1:0]               b_waddr;
  logic [7:0]                  b_byte;
  logic                        b_we;

  // result queue
  lzssd_pkg::res_t             oq [4];
  logic [1:0]                  oq_wptr;
  logic [1:0]                  oq_rptr;
  logic [2:0]                  oq_count;
  logic                        oq_pop;

  assign last_idx  = lzssd_pkg::LEN_W'(head.len_code) +
                     lzssd_pkg::LEN_W'(lzssd_pkg::MIN_MATCH - 1);
  assign slot_last = (head.kind != lzssd_pkg::CMD_COPY) || (cnt == last_idx);
  assign slot_byte = (head.kind != lzssd_pkg::CMD_NONE);
  // room for this slot and the one still in stage b
  assign issue     = head_valid && ((oq_count + 3'(b_valid)) < 3'd3);
  assign pop       = issue && slot_last;
  assign raddr     = wp_issue - head.offset;

  assign b_byte = b_copy ? (byp ? byp_data : rd_q) : b_lit;
  assign b_we   = b_valid && b_bvalid;

  always_ff @(posedge clk) begin
    if (b_we) begin
      mem[b_waddr] <= b_byte;
    end
    rd_q     <= mem[raddr];
    // offset of one reads the byte being written this cycle
    byp      <= b_we && (b_waddr == raddr);
    byp_data <= b_byte;
  end

  always_ff @(posedge clk) begin
    b_copy   <= (head.kind == lzssd_pkg::CMD_COPY);
    b_lit    <= (head.kind == lzssd_pkg::CMD_LIT) ? head.lit : 8'h00;
    b_bvalid <= slot_byte;
    b_last   <= slot_last;
    b_done   <= head.done;
    b_status <= head.status;
    b_waddr  <= wp_issue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      cnt      <= '0;
      wp_issue <= '0;
    end else begin
      b_valid <= issue;
      if (issue) begin
        cnt <= slot_last ? '0 : cnt + lzssd_pkg::LEN_W'(1);
        if (slot_byte) begin
          wp_issue <= wp_issue + AW'(1);
        end
      end
    end
  end

  assign out_valid = (oq_count != 3'd0);
  assign out_res   = oq[oq_rptr];
  assign oq_pop    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (b_valid) begin
      oq[oq_wptr] <= '{data: b_byte, byte_valid: b_bvalid, run_last: b_last,
                       frame_done: b_done, status: b_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr  <= '0;
      oq_rptr  <= '0;
      oq_count <= '0;
    end else begin
      if (b_valid) begin
        oq_wptr <= oq_wptr + 2'd1;
      end
      if (oq_pop) begin
        oq_rptr <= oq_rptr + 2'd1;
      end
      oq_count <= oq_count + 3'(b_valid) - 3'(oq_pop);
    end
  end

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(b_valid && oq_count == 3'd4 && !oq_pop))
    else $error("result queue overflow");

  a_copy_offset_nonzero: assert property (@(posedge clk) disable iff (rst)
    (issue && head.kind == lzssd_pkg::CMD_COPY) |-> (head.offset != '0))
    else $error("copy issued with zero offset");

  a_cnt_only_in_copy: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> (head_valid && head.kind == lzssd_pkg::CMD_COPY))
    else $error("slot counter running outside a copy");

endmodule

FILE: hw/rtl/lzss_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// Streaming LZSS decoder, 12-bit offset, 4-bit length, 4 KiB history.
// ----------------------------------------------------------------------------
// path: each command goes through the command queue, stage b and the result queue
// throughput: 1 input byte per cycle while the command queue is not full;
//   the engine issues one result slot per byte, so a back-reference holds it for
//   its length (3 to 18 bytes), set by the single read port of the history memory
// input keeps flowing during a copy until the 2-entry command queue is full
// reset: synchronous, clears parser state and queues, capacity to all ones;
//   the history memory is not cleared
module lzss_stream_decompressor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [8] frame_done, [10:9] status
  output logic        m_axis_tuser,   // [0] byte_valid
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  lzssd_pkg::cmd_t cmd;
  lzssd_pkg::cmd_t head;
  lzssd_pkg::res_t res;
  logic            cmd_push;
  logic            cmd_full;
  logic            cmd_pop;
  logic            head_valid;

  lzssd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd       (cmd),
    .cmd_full  (cmd_full)
  );

  lzssd_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .full       (cmd_full),
    .pop        (cmd_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lzssd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (cmd_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (res)
  );

  assign m_axis_tdata = {5'b00000, res.status, res.frame_done, res.data};
  assign m_axis_tuser = res.byte_valid;
  assign m_axis_tlast = res.run_last;

endmodule
